@@ rtl/pulse_beat_rate_detector_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef PULSE_BEAT_RATE_DETECTOR_DEFINES_SVH
`define PULSE_BEAT_RATE_DETECTOR_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define PBRD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define PBRD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pbrd_pkg.sv @@
package pbrd_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int TIME_W      = 64;
	localparam int TPS_W       = 30;
	localparam int SCALE_W     = 10;
	localparam int MIN_W       = 32;
	localparam int BPM_W       = 16;
	localparam int Q8_FRAC     = 8;
	localparam int WINDOW_DEF  = 700;

	// 6000 = 60 s/min * 100 (centi-bpm)
	localparam int                CENTI_W   = 13;
	localparam logic [CENTI_W-1:0] CENTI_MIN = 13'd6000;
	localparam int                BPM_NUM_W = TPS_W + CENTI_W;

	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W  = 2;
	localparam logic [REG_IDX_W-1:0] REG_TPS   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SCALE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN   = 2'd2;

	localparam logic [TPS_W-1:0]   TPS_RESET   = 30'd333000000;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd371;
	localparam logic [MIN_W-1:0]   MIN_RESET   = 32'd133200000;

	typedef struct packed {
		logic capture;
		logic read;
		logic update;
		logic avg_mul;
		logic avg_est;
		logic avg_chk;
		logic avg_fix;
		logic thr;
		logic decide;
		logic div_start;
		logic load_out;
	} pbrd_cmd_t;

	typedef struct packed {
		logic rate_go;
		logic div_done;
		logic out_busy;
	} pbrd_stat_t;

endpackage

@@ rtl/pbrd_if.sv @@
interface pbrd_in_if;
	import pbrd_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic [TIME_W-1:0]      time_ticks;

	modport source (output valid, output sample, output time_ticks, input ready);
	modport sink (input valid, input sample, input time_ticks, output ready);
endinterface

interface pbrd_out_if;
	import pbrd_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   average_valid;
	logic [SAMPLE_BITS-1:0] moving_average;
	logic                   beat;
	logic                   rate_valid;
	logic [BPM_W-1:0]       bpm_centi;

	modport source (output valid, output average_valid, output moving_average, output beat,
		output rate_valid, output bpm_centi, input ready);
	modport sink (input valid, input average_valid, input moving_average, input beat,
		input rate_valid, input bpm_centi, output ready);
endinterface

@@ rtl/pbrd_ctrl.sv @@
module pbrd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pbrd_pkg::pbrd_stat_t stat,
	output pbrd_pkg::pbrd_cmd_t  cmd
);
	import pbrd_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_READ = 4'd1;
	localparam logic [3:0] ST_SUM  = 4'd2;
	localparam logic [3:0] ST_AVG1 = 4'd3;
	localparam logic [3:0] ST_AVG2 = 4'd4;
	localparam logic [3:0] ST_AVG3 = 4'd5;
	localparam logic [3:0] ST_AVG4 = 4'd6;
	localparam logic [3:0] ST_THR  = 4'd7;
	localparam logic [3:0] ST_CMP  = 4'd8;
	localparam logic [3:0] ST_DIV  = 4'd9;
	localparam logic [3:0] ST_FIN  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				cmd.update = 1'b1;
				state_d    = ST_AVG1;
			end
			ST_AVG1: begin
				cmd.avg_mul = 1'b1;
				state_d     = ST_AVG2;
			end
			ST_AVG2: begin
				cmd.avg_est = 1'b1;
				state_d     = ST_AVG3;
			end
			ST_AVG3: begin
				cmd.avg_chk = 1'b1;
				state_d     = ST_AVG4;
			end
			ST_AVG4: begin
				cmd.avg_fix = 1'b1;
				state_d     = ST_THR;
			end
			ST_THR: begin
				cmd.thr = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.decide    = 1'b1;
				cmd.div_start = stat.rate_go;
				state_d       = stat.rate_go ? ST_DIV : ST_FIN;
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// hold the finished item until the output register frees up
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/pbrd_div.sv @@
module pbrd_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pbrd_pkg::BPM_NUM_W-1:0]   num,
	input  logic [pbrd_pkg::TIME_W-1:0]      den,
	output logic                              done,
	output logic [pbrd_pkg::BPM_W-1:0]       quot
);
	import pbrd_pkg::*;

	localparam int DSH_W = TIME_W + BPM_W;
	localparam int CNT_W = $clog2(BPM_W + 1);
	localparam logic [CNT_W-1:0] STEPS = CNT_W'(BPM_W);
	localparam logic [CNT_W-1:0] LAST  = CNT_W'(1);

	logic                 busy_q;
	logic                 done_q;
	logic                 ovf_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [BPM_NUM_W-1:0] rem_q;
	logic [DSH_W-2:0]     dsh_q;
	logic [BPM_W-1:0]     q_q;
	logic [DSH_W-1:0]     num_ext;
	logic [DSH_W-2:0]     rem_ext;
	logic                 fits;

	assign num_ext = DSH_W'(num);
	assign rem_ext = (DSH_W - 1)'(rem_q);
	assign fits    = (rem_ext >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - LAST;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, divisor walks right from bit 15
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {den, {(BPM_W - 1){1'b0}}};
			ovf_q <= (num_ext >= {den, {BPM_W{1'b0}}});
			q_q   <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q[BPM_NUM_W-1:0];
			end
			q_q   <= {q_q[BPM_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = ovf_q ? {BPM_W{1'b1}} : q_q;

endmodule

@@ rtl/pbrd_dpath.sv @@
module pbrd_dpath #(
	parameter int WINDOW = pbrd_pkg::WINDOW_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pbrd_pkg::pbrd_cmd_t                  cmd,
	output pbrd_pkg::pbrd_stat_t                 stat,
	input  logic [pbrd_pkg::SAMPLE_BITS-1:0]     sample,
	input  logic [pbrd_pkg::TIME_W-1:0]          time_ticks,
	input  logic                                 cfg_wr_en,
	input  logic [pbrd_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [pbrd_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 average_valid,
	output logic [pbrd_pkg::SAMPLE_BITS-1:0]     moving_average,
	output logic                                 beat,
	output logic                                 rate_valid,
	output logic [pbrd_pkg::BPM_W-1:0]           bpm_centi
);
	import pbrd_pkg::*;

	localparam int PTR_W = $clog2(WINDOW);
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;
	localparam int THR_W = SAMPLE_BITS + SCALE_W;
	// floor(2^SUM_W / WINDOW): estimate is exact or one low
	localparam logic [SUM_W-1:0] RECIP    = SUM_W'((64'd1 << SUM_W) / WINDOW);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [SUM_W-1:0] WIN_SUM  = SUM_W'(WINDOW);

	logic [TPS_W-1:0]   tps_q;
	logic [SCALE_W-1:0] scale_q;
	logic [MIN_W-1:0]   min_q;

	logic [SAMPLE_BITS-1:0] ring [WINDOW];
	logic [SAMPLE_BITS-1:0] rd_q;
	logic [SAMPLE_BITS-1:0] s_q;
	logic [TIME_W-1:0]      time_q;
	logic [PTR_W-1:0]       wp_q;
	logic [CNT_W-1:0]       fill_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] prev_q;
	logic [TIME_W-1:0]      last_q;
	logic                   seen_q;

	logic [2*SUM_W-1:0]     prod_q;
	logic [BPM_NUM_W-1:0]   num_q;
	logic [SAMPLE_BITS-1:0] qest_q;
	logic [TIME_W-1:0]      ival_q;
	logic [SUM_W-1:0]       qw_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [THR_W-1:0]       thr_q;

	logic                   valid_r_q;
	logic                   beat_r_q;
	logic                   rate_r_q;

	logic                   out_valid_q;
	logic                   avg_valid_o_q;
	logic [SAMPLE_BITS-1:0] avg_o_q;
	logic                   beat_o_q;
	logic                   rate_o_q;
	logic [BPM_W-1:0]       bpm_o_q;

	logic                   full;
	logic [SUM_W-1:0]       drop;
	logic [SUM_W-1:0]       rem;
	logic [THR_W-1:0]       s_scaled;
	logic [THR_W-1:0]       p_scaled;
	logic                   win_valid;
	logic                   beat_c;
	logic                   rate_go_c;
	logic                   div_done;
	logic [BPM_W-1:0]       quot;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q   <= TPS_RESET;
			scale_q <= SCALE_RESET;
			min_q   <= MIN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TPS:   tps_q   <= cfg_data[TPS_W-1:0];
				REG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
				REG_MIN:   min_q   <= cfg_data[MIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sample ring: oldest entry read in the cycle before it is overwritten
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_q <= ring[wp_q];
		end
		if (cmd.update) begin
			ring[wp_q] <= s_q;
		end
	end

	assign full = (fill_q == CNT_FULL);
	assign drop = full ? SUM_W'(rd_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			sum_q  <= '0;
			prev_q <= '0;
			last_q <= '0;
			seen_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				sum_q <= sum_q - drop + SUM_W'(s_q);
				wp_q  <= (wp_q == PTR_LAST) ? '0 : wp_q + PTR_ONE;
				if (!full) begin
					fill_q <= fill_q + CNT_ONE;
				end
			end
			if (cmd.decide) begin
				prev_q <= s_q;
				if (beat_c) begin
					last_q <= time_q;
					seen_q <= 1'b1;
				end
			end
		end
	end

	assign rem       = sum_q - qw_q;
	assign s_scaled  = THR_W'({s_q, {Q8_FRAC{1'b0}}});
	assign p_scaled  = THR_W'({prev_q, {Q8_FRAC{1'b0}}});
	assign win_valid = full;
	assign beat_c    = win_valid && (s_scaled > thr_q) && (p_scaled < thr_q);
	assign rate_go_c = beat_c && seen_q && (ival_q > TIME_W'(min_q));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			s_q    <= sample;
			time_q <= time_ticks;
		end
		if (cmd.avg_mul) begin
			prod_q <= (2 * SUM_W)'(sum_q) * (2 * SUM_W)'(RECIP);
			num_q  <= BPM_NUM_W'(tps_q) * BPM_NUM_W'(CENTI_MIN);
		end
		if (cmd.avg_est) begin
			qest_q <= prod_q[SUM_W +: SAMPLE_BITS];
			ival_q <= time_q - last_q;
		end
		if (cmd.avg_chk) begin
			qw_q <= SUM_W'(qest_q) * WIN_SUM;
		end
		if (cmd.avg_fix) begin
			avg_q <= (rem >= WIN_SUM) ? qest_q + SAMPLE_BITS'(1) : qest_q;
		end
		if (cmd.thr) begin
			thr_q <= THR_W'(avg_q) * THR_W'(scale_q);
		end
		if (cmd.decide) begin
			valid_r_q <= win_valid;
			beat_r_q  <= beat_c;
			rate_r_q  <= rate_go_c;
		end
	end

	pbrd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (ival_q),
		.done   (div_done),
		.quot   (quot)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			avg_valid_o_q <= valid_r_q;
			avg_o_q       <= valid_r_q ? avg_q : '0;
			beat_o_q      <= beat_r_q;
			rate_o_q      <= rate_r_q;
			bpm_o_q       <= rate_r_q ? quot : '0;
		end
	end

	assign stat.rate_go  = rate_go_c;
	assign stat.div_done = div_done;
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid      = out_valid_q;
	assign average_valid  = avg_valid_o_q;
	assign moving_average = avg_o_q;
	assign beat           = beat_o_q;
	assign rate_valid     = rate_o_q;
	assign bpm_centi      = bpm_o_q;

endmodule

@@ rtl/pulse_beat_rate_detector.sv @@
// Flow: an accepted item passes the read, sum, averaging, threshold and compare states, and
// a beat that yields a rate also waits for the 16-step quotient loop of the rate divider.
// A new item is taken only once the last result is loaded into the free output register.
// Reset: config registers return to defaults, window and crossing history clear.
// The sample ring needs no clearing pass; an entry's value is only used after it is written.
module pulse_beat_rate_detector #(
	parameter int WINDOW = pbrd_pkg::WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	pbrd_in_if.sink                           in_ch,
	pbrd_out_if.source                        out_ch,
	input  logic                              cfg_wr_en,
	input  logic [pbrd_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [pbrd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pbrd_pkg::*;

	pbrd_cmd_t  cmd;
	pbrd_stat_t stat;

	pbrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pbrd_dpath #(
		.WINDOW (WINDOW)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.sample         (in_ch.sample),
		.time_ticks     (in_ch.time_ticks),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.average_valid  (out_ch.average_valid),
		.moving_average (out_ch.moving_average),
		.beat           (out_ch.beat),
		.rate_valid     (out_ch.rate_valid),
		.bpm_centi      (out_ch.bpm_centi)
	);

endmodule

@@ rtl/pbrd_checker.sv @@
`include "pulse_beat_rate_detector_defines.svh"

module pbrd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic                             average_valid,
	input logic [pbrd_pkg::SAMPLE_BITS-1:0] moving_average,
	input logic                             beat,
	input logic                             rate_valid,
	input logic [pbrd_pkg::BPM_W-1:0]       bpm_centi
);
	import pbrd_pkg::*;

	`PBRD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`PBRD_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(moving_average) && $stable(bpm_centi) && $stable(beat) && $stable(rate_valid) && $stable(average_valid), "stalled result changed")
	// one item in flight: the block is busy right after an accept
	`PBRD_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted a second item too early")
	`PBRD_ASSERT_IMP(a_rate_needs_beat, out_valid && rate_valid, beat && average_valid, "rate without a beat")

endmodule

bind pulse_beat_rate_detector pbrd_checker u_pbrd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.average_valid  (out_ch.average_valid),
	.moving_average (out_ch.moving_average),
	.beat           (out_ch.beat),
	.rate_valid     (out_ch.rate_valid),
	.bpm_centi      (out_ch.bpm_centi)
);
